// File: src/lobe_pkg.sv
`timescale 1ns / 1ps
package lobe_pkg;
    localparam int LAT_W  = 6;
    localparam int SITE_W = 2 * LAT_W;
    localparam int NSITES = 1 << SITE_W;
    localparam int CNT_W  = 6;
    localparam int BKT_W  = 5;
    localparam int NBKT   = 1 << BKT_W;
    localparam int SIZE_W = SITE_W + 1;
    localparam int MEM_AW = BKT_W + SITE_W;
    localparam int DR_W   = 23;
    localparam int TOT_W  = 18;
    localparam logic [CNT_W-1:0] MAX_PER_SITE = CNT_W'(32);

    typedef enum logic [1:0] {ACT_ADD, ACT_REM, ACT_HOP, ACT_NONE} t_action;
    typedef enum logic [1:0] {ST_DONE, ST_FULL, ST_EMPTY} t_status;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RS, S_CS, S_CD, S_DEC,
        S_A0, S_A1, S_A2, S_AP1, S_R0, S_R1, S_R2, S_RP1
    } t_state;

    typedef struct packed {
        logic    load;
        logic    clr;
        logic    rd_src;
        logic    rd_dst;
        logic    cap_src;
        logic    cap_dst;
        logic    work_src;
        logic    work_dst;
        logic    d0;
        logic    d1;
        logic    d2;
        logic    p0;
        logic    p1;
        logic    push_add;
        logic    upd_add;
        logic    upd_rem;
        logic    emit;
        t_status st;
    } t_dp_cmd;

    typedef struct packed {
        logic    clr_done;
        t_action act;
        logic    src_zero;
        logic    src_full;
        logic    dst_block;
        logic    w_gt0;
        logic    w_gt1;
    } t_dp_stat;
endpackage

// File: src/lattice_occupancy_bucket_engine.sv
`timescale 1ns / 1ps
// Occupancy bucket engine for a 64 x 64 wrap-around lattice. After reset the
// block runs a clearing pass over every entry of the site count memory, with
// busy high; start is ignored until busy falls. An item is taken when start
// is high and busy is low, and busy then stays high until the cycle in which
// its result is shown. The result is shown for exactly one cycle with o_valid
// high; the receiver cannot stall it, so it must take it in that cycle. A new
// item can be taken in that same cycle. Refused items and those with action 3
// finish soonest, adds and removes take longer, and hops take longest. The
// time is set by the chain of dependent read-modify-writes on the
// single-ported site, slot, bucket-size and bucket-member memories, each
// read being registered.
//
// The controller sequences the steps of each action: reading the site
// counts, checking for a full or empty site, taking the site out of its old
// bucket by swapping in the bucket's last entry, and appending it to its new
// bucket. The datapath holds the memories, the death-rate and cell-total
// counters, and one non-empty flag per bucket from which the top bucket is
// priority-encoded. A hop is a remove at the source followed by an add at
// the destination.
module lattice_occupancy_bucket_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_action,
    input  logic [lobe_pkg::LAT_W-1:0]         i_pos_x,
    input  logic [lobe_pkg::LAT_W-1:0]         i_pos_y,
    input  logic signed [1:0]                  i_dir_x,
    input  logic signed [1:0]                  i_dir_y,
    output logic                               o_valid,
    output logic [1:0]                         o_status,
    output logic [lobe_pkg::CNT_W-1:0]         o_site_count,
    output logic [lobe_pkg::DR_W-1:0]          o_death_rate,
    output logic signed [lobe_pkg::CNT_W-1:0]  o_top_bucket,
    output logic [lobe_pkg::TOT_W-1:0]         o_cell_total
);
    import lobe_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer for the per-item steps and the clearing pass.
    lobe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Memories, counters and result registers.
    lobe_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_action     (i_action),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_dir_x      (i_dir_x),
        .i_dir_y      (i_dir_y),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_site_count (o_site_count),
        .o_death_rate (o_death_rate),
        .o_top_bucket (o_top_bucket),
        .o_cell_total (o_cell_total)
    );
endmodule

// File: src/lobe_ctrl.sv
`timescale 1ns / 1ps
module lobe_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  lobe_pkg::t_dp_stat i_stat,
    output lobe_pkg::t_dp_cmd  o_cmd,
    output logic               busy
);
    import lobe_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = (r_state != S_IDLE);
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RS;
                end
            end
            S_RS: begin
                o_cmd.rd_src = 1'b1;
                n_state      = S_CS;
            end
            S_CS: begin
                o_cmd.cap_src = 1'b1;
                if (i_stat.act == ACT_HOP) begin
                    o_cmd.rd_dst = 1'b1;
                    n_state      = S_CD;
                end else begin
                    n_state = S_DEC;
                end
            end
            S_CD: begin
                o_cmd.cap_dst = 1'b1;
                n_state       = S_DEC;
            end
            S_DEC: begin
                n_state = S_IDLE;
                unique case (i_stat.act)
                    ACT_ADD: begin
                        if (i_stat.src_full) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.st   = ST_FULL;
                        end else begin
                            o_cmd.work_src = 1'b1;
                            n_state        = S_A0;
                        end
                    end
                    ACT_REM, ACT_HOP: begin
                        if (i_stat.src_zero) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.st   = ST_EMPTY;
                        end else if (i_stat.act == ACT_HOP && i_stat.dst_block) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.st   = ST_FULL;
                        end else begin
                            o_cmd.work_src = 1'b1;
                            n_state        = S_R0;
                        end
                    end
                    default: begin
                        o_cmd.emit = 1'b1;
                        o_cmd.st   = ST_DONE;
                    end
                endcase
            end
            S_A0: begin
                o_cmd.push_add = 1'b1;
                if (i_stat.w_gt0) begin
                    o_cmd.d0 = 1'b1;
                    n_state  = S_A1;
                end else begin
                    o_cmd.p0 = 1'b1;
                    n_state  = S_AP1;
                end
            end
            S_A1: begin
                o_cmd.d1 = 1'b1;
                n_state  = S_A2;
            end
            S_A2: begin
                o_cmd.push_add = 1'b1;
                o_cmd.d2       = 1'b1;
                o_cmd.p0       = 1'b1;
                n_state        = S_AP1;
            end
            S_AP1: begin
                o_cmd.push_add = 1'b1;
                o_cmd.p1       = 1'b1;
                o_cmd.upd_add  = 1'b1;
                o_cmd.emit     = 1'b1;
                o_cmd.st       = ST_DONE;
                n_state        = S_IDLE;
            end
            S_R0: begin
                o_cmd.d0 = 1'b1;
                n_state  = S_R1;
            end
            S_R1: begin
                o_cmd.d1 = 1'b1;
                n_state  = S_R2;
            end
            S_R2: begin
                o_cmd.d2      = 1'b1;
                o_cmd.upd_rem = 1'b1;
                if (i_stat.w_gt1) begin
                    o_cmd.p0 = 1'b1;
                    n_state  = S_RP1;
                end else if (i_stat.act == ACT_HOP) begin
                    o_cmd.work_dst = 1'b1;
                    n_state        = S_A0;
                end else begin
                    o_cmd.emit = 1'b1;
                    o_cmd.st   = ST_DONE;
                    n_state    = S_IDLE;
                end
            end
            S_RP1: begin
                o_cmd.p1 = 1'b1;
                if (i_stat.act == ACT_HOP) begin
                    o_cmd.work_dst = 1'b1;
                    n_state        = S_A0;
                end else begin
                    o_cmd.emit = 1'b1;
                    o_cmd.st   = ST_DONE;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end
endmodule

// File: src/lobe_dp.sv
`timescale 1ns / 1ps
module lobe_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lobe_pkg::t_dp_cmd                  i_cmd,
    output lobe_pkg::t_dp_stat                 o_stat,
    input  logic [1:0]                         i_action,
    input  logic [lobe_pkg::LAT_W-1:0]         i_pos_x,
    input  logic [lobe_pkg::LAT_W-1:0]         i_pos_y,
    input  logic signed [1:0]                  i_dir_x,
    input  logic signed [1:0]                  i_dir_y,
    output logic                               o_valid,
    output logic [1:0]                         o_status,
    output logic [lobe_pkg::CNT_W-1:0]         o_site_count,
    output logic [lobe_pkg::DR_W-1:0]          o_death_rate,
    output logic signed [lobe_pkg::CNT_W-1:0]  o_top_bucket,
    output logic [lobe_pkg::TOT_W-1:0]         o_cell_total
);
    import lobe_pkg::*;

    logic [CNT_W-1:0]  cnt_mem  [NSITES];
    logic [SITE_W-1:0] slot_mem [NSITES];
    logic [SITE_W-1:0] mem_mem  [1 << MEM_AW];
    logic [SIZE_W-1:0] size_mem [NBKT];

    t_action           r_act;
    logic [SITE_W-1:0] r_src, r_dst, r_w_site, r_clr;
    logic [CNT_W-1:0]  r_c_src, r_c_dst, r_w_c, r_shown;
    logic [CNT_W-1:0]  r_cnt_q;
    logic [SIZE_W-1:0] r_sz_q;
    logic [SITE_W-1:0] r_slot_q, r_mem_q;
    logic [DR_W-1:0]   r_dr;
    logic [TOT_W-1:0]  r_tot;
    logic [NBKT-1:0]   r_ne;
    logic              r_valid;
    t_status           r_status;

    logic [BKT_W-1:0]  db, pb, sz_wa;
    logic [SIZE_W-1:0] sz_m1, sz_wd;
    logic              sz_we;
    logic [LAT_W-1:0]  dx, dy;
    logic [CNT_W-1:0]  top;

    assign db    = BKT_W'(r_w_c - CNT_W'(1));
    assign pb    = i_cmd.push_add ? BKT_W'(r_w_c) : BKT_W'(r_w_c - CNT_W'(2));
    assign sz_m1 = r_sz_q - SIZE_W'(1);
    assign dx    = i_pos_x + {{(LAT_W-2){i_dir_x[1]}}, i_dir_x};
    assign dy    = i_pos_y + {{(LAT_W-2){i_dir_y[1]}}, i_dir_y};

    always_comb begin
        sz_we = 1'b0;
        sz_wa = db;
        sz_wd = sz_m1;
        if (i_cmd.clr) begin
            sz_we = (r_clr[SITE_W-1:BKT_W] == '0);
            sz_wa = r_clr[BKT_W-1:0];
            sz_wd = '0;
        end else if (i_cmd.d1) begin
            sz_we = 1'b1;
        end else if (i_cmd.p1) begin
            sz_we = 1'b1;
            sz_wa = pb;
            sz_wd = r_sz_q + SIZE_W'(1);
        end
    end

    // Bucket sizes.
    always_ff @(posedge i_clk) begin
        if (sz_we) size_mem[sz_wa] <= sz_wd;
        if (i_cmd.d0) r_sz_q <= size_mem[db];
        else if (i_cmd.p0) r_sz_q <= size_mem[pb];
    end

    // Site counts.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) cnt_mem[r_clr] <= '0;
        else if (i_cmd.upd_add) cnt_mem[r_w_site] <= r_w_c + CNT_W'(1);
        else if (i_cmd.upd_rem) cnt_mem[r_w_site] <= r_w_c - CNT_W'(1);
        if (i_cmd.rd_src) r_cnt_q <= cnt_mem[r_src];
        else if (i_cmd.rd_dst) r_cnt_q <= cnt_mem[r_dst];
    end

    // Slot of each site inside its bucket.
    always_ff @(posedge i_clk) begin
        if (i_cmd.d2) slot_mem[r_mem_q] <= r_slot_q;
        else if (i_cmd.p1) slot_mem[r_w_site] <= r_sz_q[SITE_W-1:0];
        if (i_cmd.d0) r_slot_q <= slot_mem[r_w_site];
    end

    // Bucket member lists.
    always_ff @(posedge i_clk) begin
        if (i_cmd.d2) mem_mem[{db, r_slot_q}] <= r_mem_q;
        else if (i_cmd.p1) mem_mem[{pb, r_sz_q[SITE_W-1:0]}] <= r_w_site;
        if (i_cmd.d1) r_mem_q <= mem_mem[{db, sz_m1[SITE_W-1:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= t_action'(i_action);
            r_src <= {i_pos_y, i_pos_x};
            r_dst <= {dy, dx};
        end
        if (i_cmd.cap_src) begin
            r_c_src <= r_cnt_q;
            r_shown <= r_cnt_q;
        end
        if (i_cmd.cap_dst) begin
            r_c_dst <= r_cnt_q;
            r_shown <= r_cnt_q;
        end
        if (i_cmd.upd_add) r_shown <= r_w_c + CNT_W'(1);
        if (i_cmd.upd_rem) r_shown <= r_w_c - CNT_W'(1);
        if (i_cmd.work_src) begin
            r_w_site <= r_src;
            r_w_c    <= r_c_src;
        end else if (i_cmd.work_dst) begin
            r_w_site <= r_dst;
            r_w_c    <= (r_dst == r_src) ? r_c_src - CNT_W'(1) : r_c_dst;
        end
        if (i_cmd.emit) r_status <= i_cmd.st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_dr    <= '0;
            r_tot   <= '0;
            r_ne    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.clr) r_clr <= r_clr + SITE_W'(1);
            if (sz_we) r_ne[sz_wa] <= (sz_wd != '0);
            if (i_cmd.upd_add) begin
                r_dr  <= r_dr + DR_W'({r_w_c, 1'b1});
                r_tot <= r_tot + TOT_W'(1);
            end else if (i_cmd.upd_rem) begin
                r_dr  <= r_dr - (DR_W'({r_w_c, 1'b0}) - DR_W'(1));
                r_tot <= r_tot - TOT_W'(1);
            end
        end
    end

    always_comb begin
        top = '1;
        for (int i = 0; i < NBKT; i++) begin
            if (r_ne[i]) top = CNT_W'(i);
        end
    end

    assign o_stat.clr_done  = &r_clr;
    assign o_stat.act       = r_act;
    assign o_stat.src_zero  = (r_c_src == '0);
    assign o_stat.src_full  = (r_c_src >= MAX_PER_SITE);
    assign o_stat.dst_block = (r_dst != r_src) && (r_c_dst >= MAX_PER_SITE);
    assign o_stat.w_gt0     = (r_w_c != '0);
    assign o_stat.w_gt1     = (r_w_c > CNT_W'(1));

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_site_count = r_shown;
    assign o_death_rate = r_dr;
    assign o_top_bucket = top;
    assign o_cell_total = r_tot;
endmodule

// File: test/lattice_occupancy_checker.sv
`timescale 1ns / 1ps
module lattice_occupancy_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [1:0]                        i_action,
    input  logic [lobe_pkg::LAT_W-1:0]        i_pos_x,
    input  logic [lobe_pkg::LAT_W-1:0]        i_pos_y,
    input  logic signed [1:0]                 i_dir_x,
    input  logic signed [1:0]                 i_dir_y,
    input  logic                              o_valid,
    input  logic [1:0]                        o_status,
    input  logic [lobe_pkg::CNT_W-1:0]        o_site_count,
    input  logic [lobe_pkg::DR_W-1:0]         o_death_rate,
    input  logic signed [lobe_pkg::CNT_W-1:0] o_top_bucket,
    input  logic [lobe_pkg::TOT_W-1:0]        o_cell_total,
    output int                                fail_count,
    output int                                pending,
    output int                                item_count,
    output int                                refused_count
);
    import lobe_pkg::*;

    typedef struct packed {
        t_status           st;
        logic [CNT_W-1:0]  cnt;
        logic [DR_W-1:0]   dr;
        logic [CNT_W-1:0]  top;
        logic [TOT_W-1:0]  tot;
    } t_outcome;

    // Shadow state: site counts and the number of sites per bucket are
    // enough to reproduce every visible output.
    int       occupancy [NSITES];
    int       sites_per_bucket [NBKT];
    int       highest_bucket;
    longint   squared_sum;
    longint   cells;
    t_outcome awaited_outcomes [$];

    task automatic grow_site(input int s);
        int c;
        c = occupancy[s];
        squared_sum += 2 * c + 1;
        if (c > 0) sites_per_bucket[c-1]--;
        sites_per_bucket[c]++;
        occupancy[s] = c + 1;
        if (c > highest_bucket) highest_bucket = c;
        cells++;
    endtask

    task automatic shrink_site(input int s);
        int c;
        c = occupancy[s];
        squared_sum -= 2 * c - 1;
        sites_per_bucket[c-1]--;
        if (c > 1) sites_per_bucket[c-2]++;
        occupancy[s] = c - 1;
        while (highest_bucket >= 0 && sites_per_bucket[highest_bucket] == 0)
            highest_bucket--;
        cells--;
    endtask

    task automatic apply_action(input logic [1:0] act, input int x, input int y,
                                input int dx, input int dy);
        int src, dst, shown;
        t_outcome o;
        t_status st;
        src = y * 64 + x;
        dst = ((y + dy + 64) % 64) * 64 + ((x + dx + 64) % 64);
        shown = src;
        st = ST_DONE;
        case (t_action'(act))
            ACT_ADD: begin
                if (occupancy[src] >= 32) st = ST_FULL;
                else grow_site(src);
            end
            ACT_REM: begin
                if (occupancy[src] == 0) st = ST_EMPTY;
                else shrink_site(src);
            end
            ACT_HOP: begin
                shown = dst;
                if (occupancy[src] == 0) st = ST_EMPTY;
                else if (dst != src && occupancy[dst] >= 32) st = ST_FULL;
                else begin
                    shrink_site(src);
                    grow_site(dst);
                end
            end
            default: ;
        endcase
        if (st != ST_DONE) refused_count++;
        o.st  = st;
        o.cnt = CNT_W'(occupancy[shown]);
        o.dr  = DR_W'(squared_sum);
        o.top = CNT_W'(highest_bucket);
        o.tot = TOT_W'(cells);
        awaited_outcomes.push_back(o);
    endtask

    initial begin
        foreach (occupancy[i]) occupancy[i] = 0;
        foreach (sites_per_bucket[i]) sites_per_bucket[i] = 0;
        highest_bucket = -1;
        squared_sum = 0;
        cells = 0;
        fail_count = 0;
        item_count = 0;
        refused_count = 0;
        pending = 0;
    end

    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && start && !busy) begin
            apply_action(i_action, i_pos_x, i_pos_y, i_dir_x, i_dir_y);
            item_count++;
        end
        if (i_rst_n && o_valid) begin
            if (awaited_outcomes.size() == 0) begin
                $error("result with no item outstanding");
                fail_count++;
            end else begin
                e = awaited_outcomes.pop_front();
                if (o_status != e.st) begin
                    $error("status: expected %0d, got %0d", e.st, o_status);
                    fail_count++;
                end
                if (o_site_count != e.cnt) begin
                    $error("site_count: expected %0d, got %0d", e.cnt, o_site_count);
                    fail_count++;
                end
                if (o_death_rate != e.dr) begin
                    $error("death_rate: expected %0d, got %0d", e.dr, o_death_rate);
                    fail_count++;
                end
                if (o_top_bucket != e.top) begin
                    $error("top_bucket: expected %0d, got %0d",
                           $signed(e.top), o_top_bucket);
                    fail_count++;
                end
                if (o_cell_total != e.tot) begin
                    $error("cell_total: expected %0d, got %0d", e.tot, o_cell_total);
                    fail_count++;
                end
            end
        end
        pending = awaited_outcomes.size();
    end
endmodule

// File: test/lattice_occupancy_bucket_engine_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the occupancy bucket engine. The checker beside
// the block predicts every result; this module only issues items and decides
// on pass or fail.
module lattice_occupancy_bucket_engine_tb;
    import lobe_pkg::*;

    // A watchdog bound on cycles without any accepted item or result. It lies
    // well above the clearing pass after reset, the longest hop and the longest
    // sender gap, so it leaves a wide margin.
    localparam int IDLE_LIMIT = 20000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        i_action = '0;
    logic [LAT_W-1:0]  i_pos_x = '0;
    logic [LAT_W-1:0]  i_pos_y = '0;
    logic signed [1:0] i_dir_x = '0;
    logic signed [1:0] i_dir_y = '0;
    logic              o_valid;
    logic [1:0]        o_status;
    logic [CNT_W-1:0]  o_site_count;
    logic [DR_W-1:0]   o_death_rate;
    logic signed [CNT_W-1:0] o_top_bucket;
    logic [TOT_W-1:0]  o_cell_total;
    int fail_count, pending, item_count, refused_count;
    int idle_cycles = 0;

    always #4 i_clk = ~i_clk;

    lattice_occupancy_bucket_engine uut (.*);
    lattice_occupancy_checker checker_i (.*);

    // Any handshake on either side restarts the watchdog count.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Present one item at a falling edge and hold it until it is taken. Start
    // stays high on return so that a following item can replace it at once;
    // a gap or the end of the stimulus lowers it.
    task automatic issue_item(input t_action act, input int x, input int y,
                              input int dx, input int dy);
        i_action <= act;
        i_pos_x  <= LAT_W'(x);
        i_pos_y  <= LAT_W'(y);
        i_dir_x  <= 2'(dx);
        i_dir_y  <= 2'(dy);
        start    <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mostly short sender gaps, occasionally a long one, and runs of none.
    task automatic sender_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 50) n = 0;
        else if (n < 92) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 60);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    initial begin
        int x, y, r, dxv, dyv;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty refusals, filling a corner site to the limit,
        // a refused add to the full site, wrap-around hops, the zero-step hop
        // onto a full site, the -2 step pattern and the unused action code.
        issue_item(ACT_REM, 0, 0, 0, 0);
        issue_item(ACT_HOP, 63, 63, 1, 1);
        repeat (32) issue_item(ACT_ADD, 63, 63, 0, 0);
        issue_item(ACT_ADD, 63, 63, 0, 0);
        issue_item(ACT_HOP, 63, 63, 0, 0);
        issue_item(ACT_HOP, 63, 63, 1, 1);
        issue_item(ACT_HOP, 0, 0, -1, -1);
        issue_item(ACT_HOP, 63, 63, -2, -2);
        issue_item(ACT_NONE, 63, 63, -2, 1);
        issue_item(ACT_REM, 61, 61, 0, 0);
        issue_item(ACT_HOP, 0, 0, 1, -2);
        repeat (3) issue_item(ACT_REM, 63, 63, 0, 0);

        // Random part: a small window of sites keeps counts high enough to
        // reach full sites and deep buckets, with some items anywhere.
        repeat (500) begin
            sender_gap();
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 9) < 8) begin
                x = (62 + $urandom_range(0, 3)) % 64;
                y = (62 + $urandom_range(0, 3)) % 64;
            end else begin
                x = $urandom_range(0, 63);
                y = $urandom_range(0, 63);
            end
            dxv = int'($urandom_range(0, 3)) - 2;
            dyv = int'($urandom_range(0, 3)) - 2;
            if (r < 45) issue_item(ACT_ADD, x, y, dxv, dyv);
            else if (r < 70) issue_item(ACT_REM, x, y, dxv, dyv);
            else if (r < 96) issue_item(ACT_HOP, x, y, dxv, dyv);
            else issue_item(ACT_NONE, x, y, dxv, dyv);
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Issued %0d items (%0d refused) over adds, removes, hops", item_count,
                 refused_count);
        $display("and the unused code, including full sites and wrap-around hops.");
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
